// ----- design/video_stream_loss_tracker_core_defines.svh -----
// Assertion helpers used by the tracker back stage.
`ifndef VIDEO_STREAM_LOSS_TRACKER_CORE_DEFINES_SVH
`define VIDEO_STREAM_LOSS_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define VSLT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
`define VSLT_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define VSLT_ASSERT(lbl, clk, rstn, prop)
`define VSLT_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- design/vslt_pkg.sv -----
package vslt_pkg;

    localparam int SEQ_W       = 16;
    localparam int NB_W        = 4;
    localparam int NB1_W       = 5;
    localparam int GOP_W       = 8;
    localparam int TFC_W       = 21;
    localparam int DIV_VW      = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 21;
    localparam int FLOST_OUT_W = 21;
    localparam int TOTAL_OUT_W = 32;
    localparam int OUT_BITS    = 1 + SEQ_W + FLOST_OUT_W + 4 * TOTAL_OUT_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD     = OUT_W - OUT_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_B_FRAMES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_COUNT = 2'd2;

    localparam logic [NB_W-1:0]  NB_RESET  = 4'd2;
    localparam logic [GOP_W-1:0] GOP_RESET = 8'd12;
    localparam logic [TFC_W-1:0] TFC_RESET = 21'h100000;

    localparam int STAT_PKT_RX   = 0;
    localparam int STAT_PKT_LOST = 1;
    localparam int STAT_FRM_RX   = 2;
    localparam int STAT_FRM_DISC = 3;

    typedef enum logic [1:0] {
        KIND_I   = 2'd0,
        KIND_IDR = 2'd1,
        KIND_P   = 2'd2,
        KIND_B   = 2'd3
    } kind_t;

    typedef struct packed {
        logic fstart;
        logic fend;
        logic warm;
        logic anchor;
        logic is_p;
        logic is_b;
    } item_flags_t;

    localparam int FLG_W = $bits(item_flags_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_MOD_WAIT,
        ST_BQ,
        ST_BQ_WAIT,
        ST_MUL,
        ST_GOP,
        ST_GOP_WAIT,
        ST_APPLY
    } seq_state_t;

endpackage

// ----- design/vslt_queue.sv -----
module vslt_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- design/vslt_div.sv -----
module vslt_div #(
    parameter int DW = 21,
    parameter int VW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW:0]      rem_reg, rem_next;
    logic [VW-1:0]    div_reg, div_next;
    logic [VW:0]      rem_sh;
    logic [VW+1:0]    diff;
    logic             take;

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[VW-1:0];

    // One restoring step per cycle, most significant dividend bit first.
    assign rem_sh = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, div_reg};
    assign take   = !diff[VW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[VW:0] : rem_sh;
            quo_next = {quo_reg[DW-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ----- design/vslt_front.sv -----
module vslt_front
    import vslt_pkg::*;
#(
    parameter int FNW = 20,
    parameter int EW  = 22,
    parameter int QW  = 88
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SEQ_W-1:0]  seq_number,
    input  logic              fragment_start,
    input  logic              fragment_end,
    input  logic [FNW-1:0]    frame_number,
    input  logic [1:0]        frame_kind,
    input  logic              warmup_elapsed,
    input  logic [NB_W-1:0]   nb,
    input  logic              q_full,
    output logic              q_push,
    output logic [QW-1:0]     q_data
);

    item_flags_t       flags;
    logic signed [EW-1:0] fn_s;
    logic signed [EW-1:0] nb_s;
    logic signed [EW-1:0] enc;
    logic signed [EW-1:0] dep;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign fn_s = $signed({2'b00, frame_number});
    assign nb_s = $signed({{(EW-NB_W){1'b0}}, nb});

    always_comb
    begin
        flags.fstart = fragment_start;
        flags.fend   = fragment_end;
        flags.warm   = warmup_elapsed;
        flags.anchor = (frame_kind == KIND_I) || (frame_kind == KIND_IDR);
        flags.is_p   = (frame_kind == KIND_P);
        flags.is_b   = (frame_kind == KIND_B);
        // Encoding order: a B frame is sent after its following anchor.
        if (flags.is_b)
        begin
            enc = fn_s + $signed({{(EW-1){1'b0}}, 1'b1});
        end
        else if (flags.is_p || (frame_number != '0))
        begin
            enc = fn_s - nb_s;
        end
        else
        begin
            enc = '0;
        end
        dep = fn_s - nb_s - $signed({{(EW-1){1'b0}}, 1'b1});
    end

    assign q_data = {seq_number, frame_number, enc, dep, flags};

endmodule

// ----- design/vslt_back.sv -----
`include "video_stream_loss_tracker_core_defines.svh"
module vslt_back
    import vslt_pkg::*;
#(
    parameter int CW  = 32,
    parameter int FNW = 20,
    parameter int EW  = 22,
    parameter int QW  = 88
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [QW-1:0]          q_data,
    output logic                   q_pop,
    input  logic [NB_W-1:0]        nb,
    input  logic [GOP_W-1:0]       gop,
    input  logic [TFC_W-1:0]       tfc,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   counted,
    output logic [SEQ_W-1:0]       packets_lost_now,
    output logic [FLOST_OUT_W-1:0] frames_lost_now,
    output logic [TOTAL_OUT_W-1:0] packets_received_total,
    output logic [TOTAL_OUT_W-1:0] packets_lost_total,
    output logic [TOTAL_OUT_W-1:0] frames_received_total,
    output logic [TOTAL_OUT_W-1:0] frames_discarded_total
);

    localparam int DW  = FNW + 1;
    localparam int FLW = FNW + 1;

    seq_state_t state_reg, state_next;

    // Item under work.
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [FNW-1:0]       fn_reg, fn_next;
    logic signed [EW-1:0] enc_reg, enc_next;
    logic signed [EW-1:0] dep_reg, dep_next;
    item_flags_t          flg_reg, flg_next;

    // Tracker state.
    logic                 tracking_reg, tracking_next;
    logic [SEQ_W-1:0]     last_seq_reg, last_seq_next;
    logic signed [EW-1:0] lgi_reg, lgi_next;
    logic signed [EW-1:0] lgp_reg, lgp_next;
    logic [FNW-1:0]       cur_fn_reg, cur_fn_next;
    logic signed [EW-1:0] cur_enc_reg, cur_enc_next;
    logic                 done_reg, done_next;
    logic                 dropped_reg, dropped_next;
    logic [CW-1:0]        stat_reg [4];
    logic [CW-1:0]        stat_next [4];

    // Intermediate results of the divider passes.
    logic signed [EW-1:0] rmod_reg, rmod_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic signed [EW-1:0] lastdep_reg, lastdep_next;
    logic                 gop_hit_reg, gop_hit_next;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    logic                   o_counted_reg, o_counted_next;
    logic [SEQ_W-1:0]       o_plost_reg, o_plost_next;
    logic [FLOST_OUT_W-1:0] o_flost_reg, o_flost_next;

    // Divider hookup.
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic [DIV_VW-1:0] div_rem;

    // Working signals.
    logic                     gap_seq;
    logic signed [EW-1:0]     xval;
    logic                     xneg;
    logic [DW-1:0]            xmag;
    logic [EW-1:0]            xabs;
    logic [NB1_W-1:0]         nb1;
    logic signed [EW-1:0]     nb1_s;
    logic signed [EW-1:0]     nextdep;
    logic [GOP_W-1:0]         gop_eff;
    logic [TFC_W-1:0]         modn;
    logic [EW+DIV_VW-1:0]     rem_wide;
    logic signed [EW-1:0]     rem_s;
    logic [DW+NB1_W-1:0]      prod;
    logic [SEQ_W-1:0]         plost;
    logic signed [EW-1:0]     enc_diff;
    logic signed [EW-1:0]     enc_diffm1;
    logic [FLW-1:0]           gap_amt;
    logic                     pass;
    logic                     dropped_mid;
    logic [FLW-1:0]           flost;
    logic [FLW+FLOST_OUT_W-1:0] flost_wide;
    logic [FLW+CW-1:0]        flost_cw;
    logic [SEQ_W+CW-1:0]      plost_cw;
    logic                     out_fire;
    logic                     start_now;
    logic                     fr_inc;
    logic [CW+TOTAL_OUT_W-1:0] tot_wide [4];

    vslt_div #(
        .DW (DW),
        .VW (DIV_VW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign gap_seq  = (seq_reg != (last_seq_reg + 1'b1));
    assign xval     = cur_enc_reg + $signed({{(EW-1){1'b0}}, 1'b1});
    assign xneg     = xval[EW-1];
    assign xabs     = xneg ? (-xval) : xval;
    assign xmag     = xabs[DW-1:0];
    assign nb1      = {1'b0, nb} + 1'b1;
    assign nb1_s    = $signed({{(EW-NB1_W){1'b0}}, nb1});
    assign nextdep  = lastdep_reg + nb1_s;
    assign gop_eff  = (gop == '0) ? GOP_W'(1) : gop;
    assign modn     = (tfc == '0) ? TFC_W'(1) : tfc;
    assign rem_wide = {{EW{1'b0}}, div_rem};
    assign rem_s    = $signed(rem_wide[EW-1:0]);
    assign prod     = quo_reg * nb1;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = nextdep[DW-1:0];
        div_divisor  = {{(DIV_VW-GOP_W){1'b0}}, gop_eff};
        if (state_reg == ST_MOD)
        begin
            div_start    = tracking_reg && gap_seq;
            div_dividend = xmag;
            div_divisor  = modn;
        end
        else if (state_reg == ST_BQ)
        begin
            div_start    = tracking_reg && flg_reg.fstart && flg_reg.is_b;
            div_dividend = {1'b0, fn_reg};
            div_divisor  = {{(DIV_VW-NB1_W){1'b0}}, nb1};
        end
        else if (state_reg == ST_GOP)
        begin
            div_start = 1'b1;
        end
    end

    // Per-packet accounting, used in the apply step.
    always_comb
    begin
        plost      = (seq_reg > last_seq_reg) ? (seq_reg - last_seq_reg) : SEQ_W'(1);
        enc_diff   = enc_reg - cur_enc_reg;
        enc_diffm1 = enc_diff - $signed({{(EW-1){1'b0}}, 1'b1});
        gap_amt    = (enc_reg > cur_enc_reg) ? enc_diffm1[FLW-1:0] : '0;
        if (flg_reg.anchor)
        begin
            pass = 1'b1;
        end
        else if (flg_reg.is_p)
        begin
            pass = (lgi_reg == dep_reg) || (lgp_reg == dep_reg);
        end
        else if (gop_hit_reg)
        begin
            pass = (lgp_reg == lastdep_reg) && (lgi_reg == nextdep);
        end
        else
        begin
            pass = (lgp_reg == nextdep);
        end
        dropped_mid = dropped_reg || (gap_seq && !flg_reg.fstart);
        flost = '0;
        if (gap_seq && (enc_reg > rmod_reg))
        begin
            flost = gap_amt;
        end
        flost = flost + FLW'(gap_seq && !done_reg)
                      + FLW'(flg_reg.fstart && !pass && flg_reg.fend)
                      + FLW'(!flg_reg.fstart && flg_reg.fend && dropped_mid);
        flost_wide = {{FLOST_OUT_W{1'b0}}, flost};
        flost_cw   = {{CW{1'b0}}, flost};
        plost_cw   = {{CW{1'b0}}, plost};
    end

    assign out_fire  = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);
    assign start_now = flg_reg.warm && flg_reg.anchor && flg_reg.fstart;
    assign fr_inc    = flg_reg.fstart ? (pass && flg_reg.fend) : (flg_reg.fend && !dropped_mid);

    always_comb
    begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        seq_next       = seq_reg;
        fn_next        = fn_reg;
        enc_next       = enc_reg;
        dep_next       = dep_reg;
        flg_next       = flg_reg;
        tracking_next  = tracking_reg;
        last_seq_next  = last_seq_reg;
        lgi_next       = lgi_reg;
        lgp_next       = lgp_reg;
        cur_fn_next    = cur_fn_reg;
        cur_enc_next   = cur_enc_reg;
        done_next      = done_reg;
        dropped_next   = dropped_reg;
        stat_next      = stat_reg;
        rmod_next      = rmod_reg;
        quo_next       = quo_reg;
        lastdep_next   = lastdep_reg;
        gop_hit_next   = gop_hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_counted_next = o_counted_reg;
        o_plost_next   = o_plost_reg;
        o_flost_next   = o_flost_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    flg_next   = item_flags_t'(q_data[FLG_W-1:0]);
                    dep_next   = $signed(q_data[FLG_W+EW-1:FLG_W]);
                    enc_next   = $signed(q_data[FLG_W+2*EW-1:FLG_W+EW]);
                    fn_next    = q_data[FLG_W+2*EW+FNW-1:FLG_W+2*EW];
                    seq_next   = q_data[QW-1:QW-SEQ_W];
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                state_next = div_start ? ST_MOD_WAIT : ST_BQ;
            end
            ST_MOD_WAIT:
            begin
                if (div_done)
                begin
                    rmod_next  = xneg ? (-rem_s) : rem_s;
                    state_next = ST_BQ;
                end
            end
            ST_BQ:
            begin
                state_next = div_start ? ST_BQ_WAIT : ST_APPLY;
            end
            ST_BQ_WAIT:
            begin
                if (div_done)
                begin
                    quo_next   = div_quo;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                lastdep_next = $signed({1'b0, prod[DW-1:0]});
                state_next   = ST_GOP;
            end
            ST_GOP:
            begin
                state_next = ST_GOP_WAIT;
            end
            ST_GOP_WAIT:
            begin
                if (div_done)
                begin
                    gop_hit_next = (div_rem == '0);
                    state_next   = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    o_counted_next = 1'b0;
                    o_plost_next   = '0;
                    o_flost_next   = '0;
                    if (!tracking_reg)
                    begin
                        if (start_now)
                        begin
                            o_counted_next = 1'b1;
                            tracking_next  = 1'b1;
                            last_seq_next  = seq_reg;
                            lgp_next       = (fn_reg != '0) ? dep_reg : '1;
                            cur_fn_next    = fn_reg;
                            cur_enc_next   = enc_reg;
                            if (flg_reg.fend)
                            begin
                                done_next = 1'b1;
                                lgi_next  = $signed({2'b00, fn_reg});
                                stat_next[STAT_FRM_RX] = stat_reg[STAT_FRM_RX] + 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b0;
                                done_next    = 1'b0;
                                lgi_next     = '1;
                            end
                            stat_next[STAT_PKT_RX] = stat_reg[STAT_PKT_RX] + 1'b1;
                        end
                    end
                    else
                    begin
                        o_counted_next = 1'b1;
                        o_plost_next   = gap_seq ? plost : '0;
                        o_flost_next   = flost_wide[FLOST_OUT_W-1:0];
                        last_seq_next  = seq_reg;
                        dropped_next   = dropped_mid;
                        if (flg_reg.fstart)
                        begin
                            if (pass)
                            begin
                                if (flg_reg.is_p)
                                begin
                                    dropped_next = 1'b0;
                                end
                                if (flg_reg.fend)
                                begin
                                    done_next = 1'b1;
                                    if (flg_reg.anchor)
                                    begin
                                        lgi_next = $signed({2'b00, fn_reg});
                                    end
                                    else if (flg_reg.is_p)
                                    begin
                                        lgp_next = $signed({2'b00, fn_reg});
                                    end
                                end
                                else
                                begin
                                    dropped_next = 1'b0;
                                    done_next    = 1'b0;
                                end
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                                done_next    = flg_reg.fend;
                            end
                            cur_fn_next  = fn_reg;
                            cur_enc_next = enc_reg;
                        end
                        else if (flg_reg.fend)
                        begin
                            if (!dropped_mid)
                            begin
                                if (flg_reg.anchor)
                                begin
                                    lgi_next = $signed({2'b00, cur_fn_reg});
                                end
                                else if (flg_reg.is_p)
                                begin
                                    lgp_next = $signed({2'b00, cur_fn_reg});
                                end
                            end
                            done_next = 1'b1;
                        end
                        stat_next[STAT_PKT_RX]   = stat_reg[STAT_PKT_RX] + 1'b1;
                        stat_next[STAT_PKT_LOST] = stat_reg[STAT_PKT_LOST]
                                                   + (gap_seq ? plost_cw[CW-1:0] : '0);
                        stat_next[STAT_FRM_RX]   = stat_reg[STAT_FRM_RX] + CW'(fr_inc);
                        stat_next[STAT_FRM_DISC] = stat_reg[STAT_FRM_DISC]
                                                   + flost_cw[CW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tracking_reg  <= 1'b0;
            last_seq_reg  <= '0;
            lgi_reg       <= '1;
            lgp_reg       <= '1;
            cur_fn_reg    <= '0;
            cur_enc_reg   <= '0;
            done_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            stat_reg      <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tracking_reg  <= tracking_next;
            last_seq_reg  <= last_seq_next;
            lgi_reg       <= lgi_next;
            lgp_reg       <= lgp_next;
            cur_fn_reg    <= cur_fn_next;
            cur_enc_reg   <= cur_enc_next;
            done_reg      <= done_next;
            dropped_reg   <= dropped_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg       <= seq_next;
        fn_reg        <= fn_next;
        enc_reg       <= enc_next;
        dep_reg       <= dep_next;
        flg_reg       <= flg_next;
        rmod_reg      <= rmod_next;
        quo_reg       <= quo_next;
        lastdep_reg   <= lastdep_next;
        gop_hit_reg   <= gop_hit_next;
        o_counted_reg <= o_counted_next;
        o_plost_reg   <= o_plost_next;
        o_flost_reg   <= o_flost_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tot_wide[i] = {{TOTAL_OUT_W{1'b0}}, stat_reg[i]};
        end
    end

    assign out_valid              = out_valid_reg;
    assign counted                = o_counted_reg;
    assign packets_lost_now       = o_plost_reg;
    assign frames_lost_now        = o_flost_reg;
    assign packets_received_total = tot_wide[STAT_PKT_RX][TOTAL_OUT_W-1:0];
    assign packets_lost_total     = tot_wide[STAT_PKT_LOST][TOTAL_OUT_W-1:0];
    assign frames_received_total  = tot_wide[STAT_FRM_RX][TOTAL_OUT_W-1:0];
    assign frames_discarded_total = tot_wide[STAT_FRM_DISC][TOTAL_OUT_W-1:0];

    `VSLT_ASSERT(a_div_start_when_free, clk, rst_n, div_start |-> !div_busy)
    `VSLT_ASSERT(a_pop_only_idle, clk, rst_n, q_pop |-> (state_reg == ST_IDLE))
    `VSLT_ASSERT(a_result_not_overwritten, clk, rst_n, out_fire |-> (!out_valid_reg || out_ready))
    `VSLT_ASSERT(a_tracking_sticky, clk, rst_n, tracking_reg |=> tracking_reg)
    `VSLT_ASSERT_NEVER(a_wait_has_divider, clk, rst_n, (state_reg == ST_MOD_WAIT) && !div_busy && !div_done)

endmodule

// ----- design/video_stream_loss_tracker_core.sv -----
// Receive-side loss tracker for a packetized video stream.
// The s_ channel takes one packet header per request; the m_ channel returns
// exactly one result per request, in order. The cfg_ channel writes the
// B-frame count (index 0), the GOP size (index 1) and the trace frame count
// (index 2); it is always ready and may only be used while the block is idle.
// A front stage classifies each header and computes its encoding number, a
// two-entry queue decouples it from the back stage, which owns the tracker
// state, the running totals and one shared bit-serial divider.
// An ordinary packet passes the idle, modulo, B-quotient and apply states of
// the back stage, which pops no new header until the packet's result has been
// loaded into the output register. While tracking, a sequence gap adds a
// modulo pass of the divider; the first packet of a B frame adds two divider
// passes and a multiply. The divider produces one quotient bit per cycle.
// Reset clears the tracker state and totals and loads the default registers.
// When the receiver stalls, the finished result waits in the output register
// while the front keeps accepting until the queue holds two more headers.
module video_stream_loss_tracker_core
    import vslt_pkg::*;
#(
    parameter int COUNTER_WIDTH      = 32,
    parameter int FRAME_NUMBER_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // seq_number, fragment_start, frame_number, warmup_elapsed (low bit up)
    input  logic [((FRAME_NUMBER_WIDTH+18+7)/8)*8-1:0] s_tdata,
    // frame_kind
    input  logic [1:0]            s_tuser,
    // fragment_end
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // counted, packets_lost_now, frames_lost_now, packets_received_total,
    // packets_lost_total, frames_received_total, frames_discarded_total
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FNW = FRAME_NUMBER_WIDTH;
    localparam int EW  = FNW + 2;
    localparam int QW  = SEQ_W + FNW + 2 * EW + FLG_W;

    // Configuration registers.
    logic [NB_W-1:0]  nb_reg, nb_next;
    logic [GOP_W-1:0] gop_reg, gop_next;
    logic [TFC_W-1:0] tfc_reg, tfc_next;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_din;
    logic [QW-1:0] q_dout;

    logic                   r_counted;
    logic [SEQ_W-1:0]       r_plost;
    logic [FLOST_OUT_W-1:0] r_flost;
    logic [TOTAL_OUT_W-1:0] r_prx;
    logic [TOTAL_OUT_W-1:0] r_plt;
    logic [TOTAL_OUT_W-1:0] r_frx;
    logic [TOTAL_OUT_W-1:0] r_fdt;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        nb_next  = nb_reg;
        gop_next = gop_reg;
        tfc_next = tfc_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_B_FRAMES:    nb_next  = cfg_data[NB_W-1:0];
                CFG_GOP_SIZE:    gop_next = cfg_data[GOP_W-1:0];
                CFG_TRACE_COUNT: tfc_next = cfg_data[TFC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg  <= NB_RESET;
            gop_reg <= GOP_RESET;
            tfc_reg <= TFC_RESET;
        end
        else
        begin
            nb_reg  <= nb_next;
            gop_reg <= gop_next;
            tfc_reg <= tfc_next;
        end
    end

    vslt_front #(
        .FNW (FNW),
        .EW  (EW),
        .QW  (QW)
    ) u_front (
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .seq_number     (s_tdata[SEQ_W-1:0]),
        .fragment_start (s_tdata[SEQ_W]),
        .fragment_end   (s_tlast),
        .frame_number   (s_tdata[SEQ_W+FNW:SEQ_W+1]),
        .frame_kind     (s_tuser),
        .warmup_elapsed (s_tdata[SEQ_W+FNW+1]),
        .nb             (nb_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_din)
    );

    vslt_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    vslt_back #(
        .CW  (COUNTER_WIDTH),
        .FNW (FNW),
        .EW  (EW),
        .QW  (QW)
    ) u_back (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .q_empty                (q_empty),
        .q_data                 (q_dout),
        .q_pop                  (q_pop),
        .nb                     (nb_reg),
        .gop                    (gop_reg),
        .tfc                    (tfc_reg),
        .out_valid              (m_tvalid),
        .out_ready              (m_tready),
        .counted                (r_counted),
        .packets_lost_now       (r_plost),
        .frames_lost_now        (r_flost),
        .packets_received_total (r_prx),
        .packets_lost_total     (r_plt),
        .frames_received_total  (r_frx),
        .frames_discarded_total (r_fdt)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, r_fdt, r_frx, r_plt, r_prx,
                      r_flost, r_plost, r_counted};

endmodule
